FILE: sv/ggcd_pkg.sv
// ----------------------------------------------------------------------------
// ggcd_pkg
// Shared types and codes of the cheat code decoder: status codes, field
// widths and the per-character class record.
// ----------------------------------------------------------------------------
package ggcd_pkg;

  localparam int unsigned NUM_CHARS   = 8;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned NIBBLE_W    = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IN_DATA_W   = NUM_CHARS * CHAR_W;
  localparam int unsigned OUT_FIELD_W = STATUS_W + ADDR_W + 2 * BYTE_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LENGTH = 2'd2;

  // Code terminators
  localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;

  // Classification of one character of the code
  typedef struct packed {
    logic                term;    // zero byte or dash
    logic                letter;  // member of the sixteen-letter alphabet
    logic [NIBBLE_W-1:0] nibble;  // value of the letter
  } char_class_t;

  typedef logic [NUM_CHARS-1:0][NIBBLE_W-1:0] nibble_vec_t;

endpackage

FILE: sv/game_genie_code_decoder.sv
// ----------------------------------------------------------------------------
// game_genie_code_decoder
// Registered stages classify, scan and shuffle lie between s_* and m_*.
// Throughput: one code per cycle; each stage holds under back-pressure and
// refills its bubbles, so a stall neither drops nor repeats a beat.
// Reset: rst (synchronous, active high) clears every stage valid bit.
// ----------------------------------------------------------------------------
module game_genie_code_decoder
  import ggcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // char0 [7:0], char1 [15:8], ... char7 [63:56]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status [1:0], target_address [17:2], new_value [25:18],
  // compare_value [33:26], zero pad [39:34]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // Per-stage ready: a stage may load when it is empty or its content moves on.
  logic rdy1, rdy2, rdy_out;

  // --------------------------------------------------------------------------
  // Stage 1: classify every character in parallel.
  // --------------------------------------------------------------------------
  char_class_t cls_next [NUM_CHARS];
  char_class_t cls1     [NUM_CHARS];
  logic        v1;

  for (genvar g = 0; g < NUM_CHARS; g++) begin : g_char
    ggcd_char_class u_class (
      .ch  (s_tdata[g*CHAR_W +: CHAR_W]),
      .cls (cls_next[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      for (int i = 0; i < NUM_CHARS; i++) begin
        cls1[i] <= cls_next[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scan up to the first terminator; find bad characters and length.
  // --------------------------------------------------------------------------
  logic        bad_next, len_ok_next, is8_next;
  nibble_vec_t nib_next;
  logic        v2, bad2, len_ok2, is8_2;
  nibble_vec_t nib2;

  always_comb begin
    logic [NUM_CHARS-1:0] active;  // no terminator at or before this place
    logic                 run;
    run      = 1'b1;
    bad_next = 1'b0;
    for (int i = 0; i < NUM_CHARS; i++) begin
      run         = run && !cls1[i].term;
      active[i]   = run;
      bad_next    = bad_next || (run && !cls1[i].letter);
      nib_next[i] = cls1[i].nibble;
    end
    // Active places are a prefix, so the length is found at its edge.
    is8_next    = active[7];
    len_ok_next = active[7] || (active[5] && !active[6]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      bad2    <= bad_next;
      len_ok2 <= len_ok_next;
      is8_2   <= is8_next;
      nib2    <= nib_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: shuffle nibble bits into address and bytes; register the result.
  // --------------------------------------------------------------------------
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   target_address;
  logic [BYTE_W-1:0]   new_value, compare_value;
  logic [NIBBLE_W-1:0] lo_nib;

  always_comb begin
    lo_nib = is8_2 ? nib2[7] : nib2[5];
    if (bad2) begin
      status = STATUS_BAD_CHAR;
    end else if (!len_ok2) begin
      status = STATUS_BAD_LENGTH;
    end else begin
      status = STATUS_OK;
    end

    if (status == STATUS_OK) begin
      target_address = {1'b1, nib2[3][2:0], nib2[4][3], nib2[5][2:0],
                        nib2[1][3], nib2[2][2:0], nib2[3][3], nib2[4][2:0]};
      new_value      = {nib2[0][3], nib2[1][2:0], lo_nib[3], nib2[0][2:0]};
      if (is8_2) begin
        compare_value = {nib2[6][3], nib2[7][2:0], nib2[5][3], nib2[6][2:0]};
      end else begin
        compare_value = new_value;
      end
    end else begin
      // Zero every field on error.
      target_address = '0;
      new_value      = '0;
      compare_value  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy_out) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v2) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, compare_value, new_value, target_address, status};
    end
  end

  // Ready chain from the output back to the input.
  assign rdy_out  = !m_tvalid || m_tready;
  assign rdy2     = !v2 || rdy_out;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

endmodule

FILE: sv/ggcd_char_class.sv
// ----------------------------------------------------------------------------
// ggcd_char_class
// Map one ASCII character to terminator / letter flags and its nibble.
// ----------------------------------------------------------------------------
module ggcd_char_class
  import ggcd_pkg::*;
(
  input  logic [CHAR_W-1:0] ch,
  output char_class_t       cls
);

  always_comb begin
    cls.term   = (ch == CHAR_NUL) || (ch == CHAR_DASH);
    cls.letter = 1'b1;
    cls.nibble = 4'h0;
    case (ch)
      8'h41: cls.nibble = 4'h0;  // A
      8'h50: cls.nibble = 4'h1;  // P
      8'h5A: cls.nibble = 4'h2;  // Z
      8'h4C: cls.nibble = 4'h3;  // L
      8'h47: cls.nibble = 4'h4;  // G
      8'h49: cls.nibble = 4'h5;  // I
      8'h54: cls.nibble = 4'h6;  // T
      8'h59: cls.nibble = 4'h7;  // Y
      8'h45: cls.nibble = 4'h8;  // E
      8'h4F: cls.nibble = 4'h9;  // O
      8'h58: cls.nibble = 4'hA;  // X
      8'h55: cls.nibble = 4'hB;  // U
      8'h4B: cls.nibble = 4'hC;  // K
      8'h53: cls.nibble = 4'hD;  // S
      8'h56: cls.nibble = 4'hE;  // V
      8'h4E: cls.nibble = 4'hF;  // N
      default: cls.letter = 1'b0;
    endcase
  end

endmodule

FILE: sv/ggcd_checker.sv
// ----------------------------------------------------------------------------
// ggcd_checker
// Port-level checks of the cheat code decoder, bound to its top level.
// ----------------------------------------------------------------------------
module ggcd_checker
  import ggcd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic [STATUS_W-1:0] out_status;
  assign out_status = m_tdata[STATUS_W-1:0];

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat shown right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // A good code always points into the upper half of the address space.
  a_ok_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == STATUS_OK) |-> m_tdata[STATUS_W + ADDR_W - 1])
    else $error("ok result without address bit 15");

  // Errors carry zero fields.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != STATUS_OK) |-> (m_tdata[OUT_FIELD_W-1:STATUS_W] == '0))
    else $error("error result with nonzero fields");

  // Padding stays zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_DATA_W-1:OUT_FIELD_W] == '0))
    else $error("nonzero pad bits in result");

endmodule

bind game_genie_code_decoder ggcd_checker u_ggcd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
